// ===== sv/rse_pkg.sv =====
`default_nettype none

package rse_pkg;

  // Largest generator degree the remainder storage supports
  localparam int MAX_EC    = 30;
  // Exponent slots held in the configuration registers
  localparam int EXP_SLOTS = 30;
  // Effective degree cap
  localparam int EC_CAP    = (MAX_EC < EXP_SLOTS) ? MAX_EC : EXP_SLOTS;
  localparam int CNT_W     = $clog2(EC_CAP + 1);

  localparam int EC_W      = 5;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int GEN_W     = 64;
  localparam int GEN_D_W   = 48;

  // Register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_EC_COUNT = 3'd0;
  localparam logic [2:0] REG_GEN_A    = 3'd1;
  localparam logic [2:0] REG_GEN_B    = 3'd2;
  localparam logic [2:0] REG_GEN_C    = 3'd3;
  localparam logic [2:0] REG_GEN_D    = 3'd4;

  localparam logic [EC_W-1:0] EC_COUNT_RST = 5'd7;

  // GF(256) field polynomial and multiplicative group order
  localparam logic [8:0] GF_POLY  = 9'h11D;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef logic [7:0] gf_tab_t [256];

  typedef logic [EC_CAP-1:0][7:0] rem_t;
  typedef logic [EC_CAP-1:0][7:0] exp_vec_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } rse_in_t;

  typedef struct packed {
    logic [7:0] ec_byte;
    logic       ec_last;
  } rse_out_t;

  // One LFSR step request
  typedef struct packed {
    logic             step;
    logic             block_end;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] deg;
  } lfsr_ctl_t;

  // alpha^k table, alpha = 2
  function automatic gf_tab_t gf_exp_build();
    gf_tab_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int k = 0; k < 256; k++) begin
      t[k] = x[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  // discrete log table; entry for zero is unused
  function automatic gf_tab_t gf_log_build();
    gf_tab_t    t;
    logic [8:0] x;
    x = 9'd1;
    for (int k = 0; k < 256; k++) begin
      t[k] = 8'd0;
    end
    for (int k = 0; k < 255; k++) begin
      t[x[7:0]] = k[7:0];
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_POLY;
      end
    end
    return t;
  endfunction

  localparam gf_tab_t GF_EXP = gf_exp_build();
  localparam gf_tab_t GF_LOG = gf_log_build();

endpackage

`default_nettype wire

// ===== sv/reed_solomon_ec_encoder_core.sv =====
// Output: with the EC buffer idle, an accepted block_end item passes the input register,
//   then loads the EC burst buffer; EC items follow one per cycle while out_stall is low.
// Throughput: one data item per cycle. A block_end item holds the input
//   register (in_stall) until the previous burst of 1 to 30 EC items drains.
// Reset: synchronous active-low rst_n clears the remainder, the output burst
//   and the input register; ec_count resets to 7, the exponent registers to 0.
`default_nettype none

module reed_solomon_ec_encoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // data items
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire rse_pkg::rse_in_t           in_data,
  // EC items
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output rse_pkg::rse_out_t               out_data,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rse_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rse_pkg::DATA_W-1:0] pwdata,
  output logic [rse_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);

  logic [rse_pkg::EC_W-1:0]    ec_count_r;
  logic [rse_pkg::GEN_W-1:0]   gen_a_r;
  logic [rse_pkg::GEN_W-1:0]   gen_b_r;
  logic [rse_pkg::GEN_W-1:0]   gen_c_r;
  logic [rse_pkg::GEN_D_W-1:0] gen_d_r;
  logic [2:0]                  reg_idx;
  logic                        cfg_wr;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_count_r <= rse_pkg::EC_COUNT_RST;
      gen_a_r    <= '0;
      gen_b_r    <= '0;
      gen_c_r    <= '0;
      gen_d_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rse_pkg::REG_EC_COUNT: ec_count_r <= pwdata[rse_pkg::EC_W-1:0];
        rse_pkg::REG_GEN_A:    gen_a_r    <= pwdata;
        rse_pkg::REG_GEN_B:    gen_b_r    <= pwdata;
        rse_pkg::REG_GEN_C:    gen_c_r    <= pwdata;
        rse_pkg::REG_GEN_D:    gen_d_r    <= pwdata[rse_pkg::GEN_D_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rse_pkg::REG_EC_COUNT:
        prdata = {{(rse_pkg::DATA_W - rse_pkg::EC_W){1'b0}}, ec_count_r};
      rse_pkg::REG_GEN_A: prdata = gen_a_r;
      rse_pkg::REG_GEN_B: prdata = gen_b_r;
      rse_pkg::REG_GEN_C: prdata = gen_c_r;
      rse_pkg::REG_GEN_D:
        prdata = {{(rse_pkg::DATA_W - rse_pkg::GEN_D_W){1'b0}}, gen_d_r};
      default: prdata = '0;
    endcase
  end

  // effective degree: ec_count saturated to 1 .. cap
  logic [rse_pkg::CNT_W-1:0] deg;

  always_comb begin
    priority if (ec_count_r == '0) begin
      deg = rse_pkg::CNT_W'(1);
    end else if (32'(ec_count_r) > rse_pkg::EC_CAP) begin
      deg = rse_pkg::CNT_W'(rse_pkg::EC_CAP);
    end else begin
      deg = rse_pkg::CNT_W'(ec_count_r);
    end
  end

  // generator exponents, one byte per tap
  logic [8*rse_pkg::EXP_SLOTS-1:0] exp_flat;
  rse_pkg::exp_vec_t               exps;

  assign exp_flat = {gen_d_r, gen_c_r, gen_b_r, gen_a_r};
  assign exps     = exp_flat[8*rse_pkg::EC_CAP-1:0];

  // input register
  logic              ir_vld_r;
  logic              ir_vld_nxt;
  rse_pkg::rse_in_t  ir_r;
  logic              busy;
  logic              adv;
  logic              in_acc;
  logic              load;

  assign adv      = ir_vld_r && !(ir_r.block_end && busy);
  assign in_stall = ir_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign load     = adv && ir_r.block_end;

  always_comb begin
    priority if (in_acc) begin
      ir_vld_nxt = 1'b1;
    end else if (adv) begin
      ir_vld_nxt = 1'b0;
    end else begin
      ir_vld_nxt = ir_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_vld_r <= 1'b0;
    end else begin
      ir_vld_r <= ir_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ir_r <= in_data;
    end
  end

  // remainder LFSR
  rse_pkg::lfsr_ctl_t lfsr_ctl;
  rse_pkg::rem_t      rem_nxt;

  assign lfsr_ctl.step      = adv;
  assign lfsr_ctl.block_end = ir_r.block_end;
  assign lfsr_ctl.data_byte = ir_r.data_byte;
  assign lfsr_ctl.deg       = deg;

  rse_lfsr u_lfsr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (lfsr_ctl),
    .exps    (exps),
    .rem_nxt (rem_nxt)
  );

  // EC burst buffer: snapshot of the final remainder, shifted out byte by byte
  rse_pkg::rem_t             obuf_r;
  logic [rse_pkg::CNT_W-1:0] cnt_r;
  logic [rse_pkg::CNT_W-1:0] cnt_nxt;
  logic                      out_acc;

  assign busy             = cnt_r != '0;
  assign out_valid        = busy;
  assign out_acc          = out_valid && !out_stall;
  assign out_data.ec_byte = obuf_r[0];
  assign out_data.ec_last = cnt_r == rse_pkg::CNT_W'(1);

  always_comb begin
    priority if (load) begin
      cnt_nxt = deg;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - rse_pkg::CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obuf_r <= rem_nxt;
    end else if (out_acc) begin
      obuf_r <= {8'd0, obuf_r[rse_pkg::EC_CAP-1:1]};
    end
  end

`ifndef SYNTH
  // burst length never exceeds the degree cap
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= rse_pkg::EC_CAP)
    else $error("EC burst count out of range");

  // the last EC item empties the buffer
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.ec_last) |=> (cnt_r == '0))
    else $error("EC buffer not empty after last item");

  // input holds only for a block end waiting on a busy buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (ir_vld_r && ir_r.block_end && busy))
    else $error("input stalled without a pending block end");

  // a block end starts a burst
  a_load_burst: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid && cnt_r == $past(deg)))
    else $error("block end did not start an EC burst");
`endif

endmodule

`default_nettype wire

// ===== sv/rse_lfsr.sv =====
`default_nettype none

module rse_lfsr (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rse_pkg::lfsr_ctl_t ctl,
  input  wire rse_pkg::exp_vec_t  exps,
  output rse_pkg::rem_t           rem_nxt
);

  rse_pkg::rem_t rem_r;
  logic [7:0]    fb;
  logic [7:0]    lfb;

  // feedback and its log, shared by all taps
  assign fb  = ctl.data_byte ^ rem_r[0];
  assign lfb = rse_pkg::GF_LOG[fb];

  // all taps update in parallel
  for (genvar i = 0; i < rse_pkg::EC_CAP; i++) begin : g_tap
    logic [8:0] sum;
    logic [8:0] sum_m;
    logic [7:0] prod;
    logic [7:0] shifted;
    logic       in_deg;

    assign in_deg = rse_pkg::CNT_W'(i) < ctl.deg;
    assign sum    = {1'b0, lfb} + {1'b0, exps[i]};
    // mod 255: sum stays below 510
    assign sum_m  = (sum >= rse_pkg::GF_ORDER) ? (sum - rse_pkg::GF_ORDER) : sum;
    assign prod   = rse_pkg::GF_EXP[sum_m[7:0]];

    if (i + 1 < rse_pkg::EC_CAP) begin : g_mid
      assign shifted = (rse_pkg::CNT_W'(i + 1) < ctl.deg) ? rem_r[i + 1] : 8'd0;
    end else begin : g_top
      assign shifted = 8'd0;
    end

    assign rem_nxt[i] = !in_deg ? 8'd0 :
                        (fb != 8'd0) ? (shifted ^ prod) : shifted;
  end

  // remainder clears after the last data byte of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (ctl.step) begin
      rem_r <= ctl.block_end ? '0 : rem_nxt;
    end
  end

endmodule

`default_nettype wire
